>>> sv/vco_tune_step_calibrator_core_macros.svh
// ----------------------------------------------------------------------------
// vco tune step calibrator assertion macros
// shared concurrent assertion forms, reset-qualified
// ----------------------------------------------------------------------------
`ifndef VCO_TUNE_STEP_CALIBRATOR_CORE_MACROS_SVH
`define VCO_TUNE_STEP_CALIBRATOR_CORE_MACROS_SVH

// same-cycle implication
`define VTSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VTSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/vtsc_pkg.sv
// ----------------------------------------------------------------------------
// vtsc_pkg
// types and constants shared by the vco tune step calibrator
// ----------------------------------------------------------------------------
package vtsc_pkg;

	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned QUO_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NUM = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_START = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFS  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RAIL_LIMIT = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_BAND  = 4'd7;

	localparam logic [15:0] PERIOD_SAT = 16'hFFFF;
	localparam logic [15:0] COUNT_SAT  = 16'hFFFF;

	typedef struct packed {
		logic [31:0] period_numerator;
		logic [31:0] freq_start;
		logic [23:0] freq_step;
		logic [15:0] hold_limit;
		logic [11:0] level_max;
		logic [11:0] level_offset;
		logic [15:0] rail_limit;
		logic [7:0]  near_band;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		period_numerator: 32'd0,
		freq_start:       32'd0,
		freq_step:        24'd0,
		hold_limit:       16'd100,
		level_max:        12'd3000,
		level_offset:     12'd112,
		rail_limit:       16'd100,
		near_band:        8'd2
	};

	typedef struct packed {
		logic        ready;
		logic [15:0] period;
	} tgt_t;

endpackage

>>> sv/vco_tune_step_calibrator_core.sv
// ----------------------------------------------------------------------------
// vco_tune_step_calibrator_core
// oscillator tuning dac calibration, one measured period per request
// ----------------------------------------------------------------------------
// output: result registered, valid in the cycle after the request is taken
// throughput: one request per cycle while the target period is current and the output is not stalled
// a step advance or a write to the numerator or frequency registers
// reloads the target through the bit-serial multiply over the step index,
// the divisor sum and the bit-serial restoring divider
// reset: asynchronous, control and config registers to defaults, target computed before input
// ----------------------------------------------------------------------------
`include "vco_tune_step_calibrator_core_macros.svh"

module vco_tune_step_calibrator_core #(
	parameter int unsigned STEPS    = 256,
	parameter int unsigned DAC_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [15:0]                          measured_period,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [11:0]                          dac_level,
	output logic                                 entry_write,
	output logic [8:0]                           entry_index,
	output logic [11:0]                          entry_value,
	output logic                                 done_res,
	output logic                                 device_error,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vtsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vtsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned IW = $clog2(STEPS + 2);
	localparam logic [16:0] CODE_MAX = 17'((1 << DAC_BITS) - 1);

	vtsc_pkg::cfg_t  cfg;
	vtsc_pkg::tgt_t  tgt;
	logic            refresh;
	logic            req_q;

	logic [11:0]     level_q;
	logic [IW-1:0]   step_q;
	logic [15:0]     hold_q;
	logic [15:0]     rail_q;
	logic            err_q;

	logic            out_valid_q;
	logic [11:0]     dac_level_q;
	logic            entry_write_q;
	logic [8:0]      entry_index_q;
	logic [11:0]     entry_value_q;
	logic            done_q;
	logic            device_error_q;

	logic            accept;
	logic [11:0]     lmax;
	logic            active;
	logic            match;
	logic [15:0]     hold_inc;
	logic            adv;
	logic [15:0]     period_gap;
	logic            near;
	logic            go_up;
	logic            go_dn;
	logic            railed;
	logic [15:0]     rail_inc;
	logic            trip;
	logic [11:0]     entry_val;
	logic [11:0]     level_nx;
	logic [IW-1:0]   step_nx;
	logic [15:0]     hold_nx;
	logic [15:0]     rail_nx;
	logic            err_nx;

	assign cfg_ready = 1'b1;

	vtsc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.refresh  (refresh)
	);

	vtsc_target #(
		.IW (IW)
	) u_target (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.cfg    (cfg),
		.index  (step_q),
		.tgt    (tgt)
	);

	assign in_ready = tgt.ready && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;

	always_comb begin
		lmax = ({5'd0, cfg.level_max} < CODE_MAX) ? cfg.level_max : CODE_MAX[11:0];
		active = !err_q && (step_q <= IW'(STEPS));
		match = measured_period == tgt.period;
		hold_inc = (hold_q == vtsc_pkg::COUNT_SAT) ? hold_q : hold_q + 16'd1;
		adv = active && match && (hold_inc > cfg.hold_limit);
		period_gap = (measured_period > tgt.period) ? measured_period - tgt.period :
			tgt.period - measured_period;
		near = period_gap < {8'd0, cfg.near_band};
		go_up = (measured_period < tgt.period) && (level_q < lmax);
		go_dn = (measured_period > tgt.period) && (level_q != 12'd0);
		railed = (level_q >= lmax) || (level_q == 12'd0);
		rail_inc = (rail_q == vtsc_pkg::COUNT_SAT) ? rail_q : rail_q + 16'd1;
		trip = rail_inc > cfg.rail_limit;
		entry_val = (level_q > cfg.level_offset) ? level_q - cfg.level_offset : 12'd0;

		level_nx = level_q;
		step_nx = step_q;
		hold_nx = hold_q;
		rail_nx = rail_q;
		err_nx = err_q;
		if (active) begin
			if (match) begin
				hold_nx = adv ? 16'd0 : hold_inc;
				if (adv)
					step_nx = step_q + IW'(1);
			end else begin
				hold_nx = (near && hold_q != 16'd0) ? hold_q - 16'd1 : 16'd0;
				priority if (go_up) begin
					level_nx = level_q + 12'd1;
				end else if (go_dn) begin
					level_nx = level_q - 12'd1;
				end else if (railed) begin
					rail_nx = trip ? 16'd0 : rail_inc;
					err_nx = err_q || trip;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= 1'b1;
			level_q <= '0;
			step_q <= '0;
			hold_q <= '0;
			rail_q <= '0;
			err_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			req_q <= refresh || (accept && adv);
			if (accept) begin
				level_q <= level_nx;
				step_q <= step_nx;
				hold_q <= hold_nx;
				rail_q <= rail_nx;
				err_q <= err_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dac_level_q <= level_nx;
			entry_write_q <= adv;
			entry_index_q <= adv ? 9'(step_q) : 9'd0;
			entry_value_q <= adv ? entry_val : 12'd0;
			done_q <= step_nx > IW'(STEPS);
			device_error_q <= err_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign dac_level = dac_level_q;
	assign entry_write = entry_write_q;
	assign entry_index = entry_index_q;
	assign entry_value = entry_value_q;
	assign done_res = done_q;
	assign device_error = device_error_q;

	`VTSC_ASSERT_NXT(a_adv_stalls_input, clk, arst_n, accept && adv, !in_ready, "request taken while target period stale")
	`VTSC_ASSERT_NXT(a_cfg_stalls_input, clk, arst_n, refresh, !in_ready, "request taken before target reload")
	`VTSC_ASSERT_NXT(a_error_sticky, clk, arst_n, err_q, err_q, "error flag cleared")
	`VTSC_ASSERT_IMP(a_entry_without_error, clk, arst_n, out_valid_q && entry_write_q, !device_error_q, "entry written while error set")

endmodule

>>> sv/vtsc_cfg.sv
// ----------------------------------------------------------------------------
// vtsc_cfg
// configuration register file, flags writes that change the target period
// ----------------------------------------------------------------------------
module vtsc_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [vtsc_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [vtsc_pkg::CFG_DATA_W-1:0]      wr_data,
	output vtsc_pkg::cfg_t                       cfg,
	output logic                                 refresh
);

	vtsc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= vtsc_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				vtsc_pkg::REG_PERIOD_NUM: cfg_q.period_numerator <= wr_data;
				vtsc_pkg::REG_FREQ_START: cfg_q.freq_start <= wr_data;
				vtsc_pkg::REG_FREQ_STEP:  cfg_q.freq_step <= wr_data[23:0];
				vtsc_pkg::REG_HOLD_LIMIT: cfg_q.hold_limit <= wr_data[15:0];
				vtsc_pkg::REG_LEVEL_MAX:  cfg_q.level_max <= wr_data[11:0];
				vtsc_pkg::REG_LEVEL_OFS:  cfg_q.level_offset <= wr_data[11:0];
				vtsc_pkg::REG_RAIL_LIMIT: cfg_q.rail_limit <= wr_data[15:0];
				vtsc_pkg::REG_NEAR_BAND:  cfg_q.near_band <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
	assign refresh = wr_en && (wr_index == vtsc_pkg::REG_PERIOD_NUM ||
		wr_index == vtsc_pkg::REG_FREQ_START || wr_index == vtsc_pkg::REG_FREQ_STEP);

endmodule

>>> sv/vtsc_target.sv
// ----------------------------------------------------------------------------
// vtsc_target
// target period unit: bit-serial step multiply, then bit-serial restoring
// division of the numerator, quotient saturated to 16 bits
// ----------------------------------------------------------------------------
`include "vco_tune_step_calibrator_core_macros.svh"

module vtsc_target #(
	parameter int unsigned IW = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req,
	input  vtsc_pkg::cfg_t   cfg,
	input  logic [IW-1:0]    index,
	output vtsc_pkg::tgt_t   tgt
);

	localparam int unsigned PW = 24 + IW;
	localparam int unsigned DW = ((PW > 32) ? PW : 32) + 1;
	localparam int unsigned CW = $clog2(((IW > vtsc_pkg::QUO_W) ? IW : vtsc_pkg::QUO_W) + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [1:0]                  state_q;
	logic [CW-1:0]               cnt_q;
	logic [PW-1:0]               acc_q;
	logic [PW-1:0]               mcand_q;
	logic [IW-1:0]               mplier_q;
	logic [DW-1:0]               den_q;
	logic [DW-1:0]               rem_q;
	logic [vtsc_pkg::QUO_W-1:0]  num_q;
	logic [vtsc_pkg::QUO_W-1:0]  quo_q;
	logic [15:0]                 period_q;

	logic [DW:0]                 rem_sh;
	logic                        ge;
	logic [DW-1:0]               rem_nx;
	logic [vtsc_pkg::QUO_W-1:0]  quo_nx;
	logic                        last_div;

	always_comb begin
		rem_sh = {rem_q, num_q[vtsc_pkg::QUO_W-1]};
		ge = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
		quo_nx = {quo_q[vtsc_pkg::QUO_W-2:0], ge};
		last_div = cnt_q == CW'(vtsc_pkg::QUO_W - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else if (req) begin
			state_q <= ST_MUL;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_MUL: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(IW - 1))
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_DIV;
					cnt_q <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (den_q == '0 || last_div)
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req) begin
			acc_q <= '0;
			mcand_q <= PW'(cfg.freq_step);
			mplier_q <= index;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_MUL: begin
					if (mplier_q[0])
						acc_q <= acc_q + mcand_q;
					mcand_q <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
				ST_ADD: begin
					den_q <= DW'(cfg.freq_start) + DW'(acc_q);
					rem_q <= '0;
					num_q <= cfg.period_numerator;
					quo_q <= '0;
				end
				ST_DIV: begin
					if (den_q == '0) begin
						period_q <= vtsc_pkg::PERIOD_SAT;
					end else begin
						rem_q <= rem_nx;
						num_q <= num_q << 1;
						quo_q <= quo_nx;
						if (last_div)
							period_q <= (|quo_nx[vtsc_pkg::QUO_W-1:16]) ?
								vtsc_pkg::PERIOD_SAT : quo_nx[15:0];
					end
				end
			endcase
		end
	end

	assign tgt.ready = (state_q == ST_IDLE) && !req;
	assign tgt.period = period_q;

	`VTSC_ASSERT_IMP(a_rem_below_den, clk, arst_n, state_q == ST_DIV && den_q != '0, rem_q < den_q, "partial remainder not below divisor")
	`VTSC_ASSERT_IMP(a_mul_count, clk, arst_n, state_q == ST_MUL, cnt_q < CW'(IW), "multiply ran past index width")
	`VTSC_ASSERT_NXT(a_add_to_div, clk, arst_n, state_q == ST_ADD && !req, state_q == ST_DIV, "divisor sum not followed by division")

endmodule

>>> test/vco_tune_step_calibrator_core_tb.sv
// ----------------------------------------------------------------------------
// vco_tune_step_calibrator_core_tb
// self-checking bench for the oscillator tuning dac calibrator: a table of
// directed requests and register writes, then random periods aimed mostly at
// the current target, checked result by result against table values or an
// in-bench predictor of level, step, hold and rail counters, under three idling regimes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vco_tune_step_calibrator_core_tb;

	localparam int unsigned STEPS = 256;
	localparam int unsigned DAC_BITS = 12;
	localparam logic [11:0] DAC_TOP = 12'((1 << DAC_BITS) - 1);
	localparam logic [vtsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd12;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_REQUESTS = 160;
	localparam int unsigned MATCH_CEILING = 200;

	typedef struct packed {
		logic [11:0] dac_level;
		logic        entry_write;
		logic [8:0]  entry_index;
		logic [11:0] entry_value;
		logic        done_res;
		logic        device_error;
	} tune_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [vtsc_pkg::CFG_IDX_W-1:0]  idx;
		logic [vtsc_pkg::CFG_DATA_W-1:0] data;
		logic [15:0]                     period;
		logic                            typed;
		tune_result_t                    want;
	} stim_row_t;

	localparam tune_result_t NO_RES = '0;
	localparam int unsigned PLAN_LEN = 30;

	localparam stim_row_t PLAN [PLAN_LEN] = '{
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'd0, 1'b1,
			'{12'd1, 1'b0, 9'd0, 12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'hFFFF, 1'b1,
			'{12'd1, 1'b0, 9'd0, 12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'hFFFE, 1'b1,
			'{12'd2, 1'b0, 9'd0, 12'd0, 1'b0, 1'b0}},
		'{ROW_CFG, REG_UNUSED, 32'hFFFFFFFF, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'hFFFF, 1'b1,
			'{12'd2, 1'b0, 9'd0, 12'd0, 1'b0, 1'b0}},
		'{ROW_CFG, vtsc_pkg::REG_HOLD_LIMIT, 32'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'hFFFF, 1'b1,
			'{12'd2, 1'b1, 9'd0, 12'd0, 1'b0, 1'b0}},
		'{ROW_CFG, vtsc_pkg::REG_LEVEL_OFS, 32'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'hFFFF, 1'b1,
			'{12'd2, 1'b1, 9'd1, 12'd2, 1'b0, 1'b0}},
		'{ROW_CFG, vtsc_pkg::REG_LEVEL_MAX, 32'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'd0, 1'b1,
			'{12'd2, 1'b0, 9'd0, 12'd0, 1'b0, 1'b0}},
		'{ROW_CFG, vtsc_pkg::REG_RAIL_LIMIT, 32'h0000FFFF, 16'd0, 1'b0, NO_RES},
		'{ROW_CFG, vtsc_pkg::REG_LEVEL_MAX, 32'h00000FFF, 16'd0, 1'b0, NO_RES},
		'{ROW_CFG, vtsc_pkg::REG_PERIOD_NUM, 32'hFFFFFFFF, 16'd0, 1'b0, NO_RES},
		'{ROW_CFG, vtsc_pkg::REG_FREQ_START, 32'd1, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'hFFFF, 1'b1,
			'{12'd2, 1'b1, 9'd2, 12'd2, 1'b0, 1'b0}},
		'{ROW_CFG, vtsc_pkg::REG_FREQ_STEP, 32'hFFFFFFFF, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'd85, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'd84, 1'b0, NO_RES},
		'{ROW_CFG, vtsc_pkg::REG_NEAR_BAND, 32'd255, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'd200, 1'b0, NO_RES},
		'{ROW_CFG, vtsc_pkg::REG_NEAR_BAND, 32'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'd63, 1'b0, NO_RES},
		'{ROW_CFG, vtsc_pkg::REG_HOLD_LIMIT, 32'hFFFFFFFF, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'd64, 1'b0, NO_RES},
		'{ROW_CFG, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'hFFFF, 1'b0, NO_RES},
		'{ROW_CFG, vtsc_pkg::REG_FREQ_START, 32'hFFFFFFFF, 16'd0, 1'b0, NO_RES},
		'{ROW_ITEM, vtsc_pkg::REG_PERIOD_NUM, 32'd0, 16'd0, 1'b0, NO_RES}
	};

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [15:0]                     measured_period = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [11:0]                     dac_level;
	logic                            entry_write;
	logic [8:0]                      entry_index;
	logic [11:0]                     entry_value;
	logic                            done_res;
	logic                            device_error;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [vtsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [vtsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	vco_tune_step_calibrator_core #(
		.STEPS(STEPS),
		.DAC_BITS(DAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.measured_period(measured_period),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dac_level(dac_level),
		.entry_write(entry_write),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.done_res(done_res),
		.device_error(device_error),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predicted calibrator state
	vtsc_pkg::cfg_t cal_cfg = vtsc_pkg::CFG_RESET;
	logic [11:0]    cal_level = '0;
	logic [8:0]     cal_step = '0;
	logic [15:0]    cal_target = vtsc_pkg::PERIOD_SAT;
	logic [15:0]    cal_hold = '0;
	logic [15:0]    cal_rail = '0;
	logic           cal_err = 1'b0;

	tune_result_t calib_due [$];
	tune_result_t seen_want;
	int unsigned  mismatch_count = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  src_idle = 0;
	int unsigned  snk_idle = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [15:0] target_period_for(input logic [8:0] step);
		logic [63:0] den;
		logic [63:0] quo;
		den = 64'(cal_cfg.freq_start) + 64'(cal_cfg.freq_step) * 64'(step);
		if (den == 64'd0)
			return vtsc_pkg::PERIOD_SAT;
		quo = 64'(cal_cfg.period_numerator) / den;
		return (quo > 64'(vtsc_pkg::PERIOD_SAT)) ? vtsc_pkg::PERIOD_SAT : quo[15:0];
	endfunction

	task automatic apply_register(input logic [vtsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [vtsc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			vtsc_pkg::REG_PERIOD_NUM: begin
				cal_cfg.period_numerator = data;
				cal_target = target_period_for(cal_step);
			end
			vtsc_pkg::REG_FREQ_START: begin
				cal_cfg.freq_start = data;
				cal_target = target_period_for(cal_step);
			end
			vtsc_pkg::REG_FREQ_STEP: begin
				cal_cfg.freq_step = data[23:0];
				cal_target = target_period_for(cal_step);
			end
			vtsc_pkg::REG_HOLD_LIMIT: cal_cfg.hold_limit = data[15:0];
			vtsc_pkg::REG_LEVEL_MAX:  cal_cfg.level_max = data[11:0];
			vtsc_pkg::REG_LEVEL_OFS:  cal_cfg.level_offset = data[11:0];
			vtsc_pkg::REG_RAIL_LIMIT: cal_cfg.rail_limit = data[15:0];
			vtsc_pkg::REG_NEAR_BAND:  cal_cfg.near_band = data[7:0];
			default: ;
		endcase
	endtask

	task automatic calibrate_period(input logic [15:0] period, output tune_result_t res);
		logic [11:0] lmax;
		logic [15:0] period_gap;
		res = '0;
		lmax = (cal_cfg.level_max < DAC_TOP) ? cal_cfg.level_max : DAC_TOP;
		if (!cal_err && cal_step <= STEPS) begin
			if (period == cal_target) begin
				if (cal_hold < vtsc_pkg::COUNT_SAT)
					cal_hold++;
				if (cal_hold > cal_cfg.hold_limit) begin
					cal_hold = '0;
					res.entry_write = 1'b1;
					res.entry_index = cal_step;
					res.entry_value = (cal_level > cal_cfg.level_offset) ?
						cal_level - cal_cfg.level_offset : 12'd0;
					cal_step++;
					cal_target = target_period_for(cal_step);
				end
			end else begin
				period_gap = (period > cal_target) ? period - cal_target :
					cal_target - period;
				if (period_gap < 16'(cal_cfg.near_band)) begin
					if (cal_hold != 16'd0)
						cal_hold--;
				end else begin
					cal_hold = '0;
				end
				if (period < cal_target && cal_level < lmax) begin
					cal_level++;
				end else if (period > cal_target && cal_level != 12'd0) begin
					cal_level--;
				end else if (cal_level >= lmax || cal_level == 12'd0) begin
					// railed at either end
					if (cal_rail < vtsc_pkg::COUNT_SAT)
						cal_rail++;
					if (cal_rail > cal_cfg.rail_limit) begin
						cal_rail = '0;
						cal_err = 1'b1;
					end
				end
			end
		end
		res.dac_level = cal_level;
		res.done_res = (cal_step > STEPS);
		res.device_error = cal_err;
	endtask

	function automatic logic [15:0] pick_period(input bit allow_match);
		int t;
		int off;
		int v;
		int r;
		t = int'(cal_target);
		r = $urandom_range(0, 99);
		if (r < 45 && allow_match)
			return cal_target;
		if (r < 65) begin
			off = $urandom_range(1, (cal_cfg.near_band > 8'd1) ? cal_cfg.near_band - 1 : 1);
			v = $urandom_range(0, 1) ? t + off : t - off;
			if (v < 0)
				v = t + off;
			if (v > 65535)
				v = t - off;
			return v[15:0];
		end
		if (r < 90)
			return 16'($urandom);
		if (r < 95)
			return 16'd0;
		return 16'hFFFF;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic set_idling(input int unsigned regime);
		src_idle = (regime == 0) ? 32 : (regime == 1) ? 80 : 0;
		snk_idle = (regime == 0) ? 80 : (regime == 1) ? 32 : 0;
	endtask

	// one period request, expectation queued at acceptance
	task automatic push_period(input logic [15:0] period, input logic typed,
			input tune_result_t want);
		tune_result_t res;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		measured_period <= period;
		do @(posedge clk); while (!in_ready);
		calibrate_period(period, res);
		calib_due.push_back(typed ? want : res);
	endtask

	task automatic write_reg(input logic [vtsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [vtsc_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain results, then allow a target reload to finish
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (calib_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mode 0: ordinary phase, 1: run to done, 2: run to device error
	task automatic load_settings(input int unsigned mode);
		logic [31:0] start;
		logic [31:0] step;
		start = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(4096, 1 << 22);
		step = $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 14)) : $urandom;
		if (start == 32'd0)
			step = 32'd0;
		settle();
		write_reg(vtsc_pkg::REG_PERIOD_NUM, $urandom);
		write_reg(vtsc_pkg::REG_FREQ_START, start);
		write_reg(vtsc_pkg::REG_FREQ_STEP, step);
		write_reg(vtsc_pkg::REG_HOLD_LIMIT, (mode == 1) ? 32'd0 : $urandom_range(1, 4));
		write_reg(vtsc_pkg::REG_LEVEL_MAX, (mode == 2) ? 32'd0 :
			($urandom_range(0, 3) == 0) ? 32'd4095 : $urandom_range(0, 48));
		write_reg(vtsc_pkg::REG_LEVEL_OFS, $urandom_range(0, 48));
		write_reg(vtsc_pkg::REG_RAIL_LIMIT,
			(mode == 2) ? $urandom_range(0, 4) : 32'd65535);
		write_reg(vtsc_pkg::REG_NEAR_BAND, $urandom_range(0, 8));
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= snk_idle);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (calib_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing due, dac_level %0d", dac_level));
			end else begin
				seen_want = calib_due.pop_front();
				compare_field("dac_level", 32'(dac_level), 32'(seen_want.dac_level));
				compare_field("entry_write", 32'(entry_write), 32'(seen_want.entry_write));
				compare_field("entry_index", 32'(entry_index), 32'(seen_want.entry_index));
				compare_field("entry_value", 32'(entry_value), 32'(seen_want.entry_value));
				compare_field("done_res", 32'(done_res), 32'(seen_want.done_res));
				compare_field("device_error", 32'(device_error),
					32'(seen_want.device_error));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		set_idling(0);
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_CFG) begin
				settle();
				write_reg(PLAN[i].idx, PLAN[i].data);
			end else begin
				push_period(PLAN[i].period, PLAN[i].typed, PLAN[i].want);
			end
		end

		for (int ph = 0; ph < 5; ph++) begin
			set_idling(ph / 2);
			load_settings(0);
			repeat (PHASE_REQUESTS)
				push_period(pick_period(cal_step < MATCH_CEILING), 1'b0, NO_RES);
		end

		// closing phase ends frozen, by completion or by railing
		set_idling(2);
		load_settings($urandom_range(1, 2));
		while (!(cal_err || cal_step > STEPS))
			push_period(pick_period(1'b1), 1'b0, NO_RES);
		repeat (20)
			push_period(pick_period(1'b1), 1'b0, NO_RES);

		@(negedge clk);
		in_valid <= 1'b0;
		while (calib_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (calib_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", calib_due.size()));
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
